/* sv/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* sv/mcaa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mcaa_pkg;

  // Field widths fixed by the item format.
  localparam int READING_WIDTH   = 16;
  localparam int SUM_WIDTH       = 48;
  localparam int CHAN_FIELD_W    = 3;
  localparam int WORD_W          = READING_WIDTH + SUM_WIDTH;
  localparam int OUT_TDATA_W     = 40;

  // Defaults for the top-level parameters.
  localparam int DEF_CHANNELS    = 7;
  localparam int DEF_COUNT_WIDTH = 32;

  // Opcodes carried in tuser of the input channel.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_RD,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

/* sv/mcaa_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial signed divider: a signed sum divided by an unsigned count,
// one quotient bit per cycle, quotient truncated toward zero.
module mcaa_div
  import mcaa_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [SUM_WIDTH-1:0]     dividend,
  input  wire logic [COUNT_WIDTH-1:0]   divisor,
  output logic                          done,
  output logic [READING_WIDTH-1:0]      quotient
);

  localparam int CNT_W = $clog2(SUM_WIDTH + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SUM_WIDTH - 1);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       step_r;
  logic                   neg_r;
  logic [SUM_WIDTH-1:0]   dvd_r;
  logic [COUNT_WIDTH-1:0] dvs_r;
  logic [COUNT_WIDTH-1:0] rem_r;

  logic [COUNT_WIDTH:0]   rem_shift;
  logic [COUNT_WIDTH:0]   rem_diff;
  logic                   fits;
  logic [SUM_WIDTH-1:0]   dvd_abs;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_shift = {rem_r, dvd_r[SUM_WIDTH-1]};
    rem_diff  = rem_shift - {1'b0, dvs_r};
    fits      = (rem_shift >= {1'b0, dvs_r});
    dvd_abs   = dividend[SUM_WIDTH-1] ? (~dividend + 1'b1) : dividend;
  end

  // Control: busy while stepping, done pulses after the last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dvd_abs;
      dvs_r <= divisor;
      rem_r <= '0;
      neg_r <= dividend[SUM_WIDTH-1];
    end else if (busy_r) begin
      dvd_r <= {dvd_r[SUM_WIDTH-2:0], fits};
      rem_r <= fits ? rem_diff[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~dvd_r[READING_WIDTH-1:0] + 1'b1)
                          : dvd_r[READING_WIDTH-1:0];

endmodule

`default_nettype wire

/* sv/mcaa_store.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel memory: one word per channel holding the latest reading and the
// running sum. Synchronous read with registered read data; a valid bit per
// entry makes entries never written read as zero after reset.
module mcaa_store
  import mcaa_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int AW       = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0]      rd_data,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0]   mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  logic [WORD_W-1:0]   rd_data_r;
  logic                rd_vld_r;

  // Storage array, written and read in clocked logic.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Per-entry valid bits cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

/* sv/multichannel_accumulate_average.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Word contents
// in_     | in  | tuser: opcode; tdata: reading_0 .. reading_(CHANNELS-1)
// out_    | out | tdata: channel, average, latest; tuser: no_samples; tlast: last
//
// A sample word takes one read-modify-write of the channel memory per channel,
// with the next read overlapping the current write.
// A read word is paced by the bit-serial divider, which serves the channels one
// after another, and by any output stalls.
// A sample word that arrives with the count saturated is taken and dropped.
// Reset is synchronous and active low; the memory needs no clearing pass.
module multichannel_accumulate_average
  import mcaa_pkg::*;
#(
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // reading_0 in bits 15:0, then reading_1 and up, 16 bits each
  input  wire logic [CHANNELS*READING_WIDTH-1:0] in_tdata,
  // opcode
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // channel [2:0], average [18:3], latest [34:19], zero fill [39:35]
  output logic [OUT_TDATA_W-1:0]                 out_tdata,
  // no_samples
  output logic                                   out_tuser,
  output logic                                   out_tlast
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [AW-1:0] LAST_CH = AW'(CHANNELS - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  state_t state_r, state_nxt;

  logic [AW-1:0]                     ch_r;
  logic [CHANNELS*READING_WIDTH-1:0] smp_r;
  logic [COUNT_WIDTH-1:0]            count_r;
  logic [COUNT_WIDTH-1:0]            divisor_r;
  logic                              none_r;
  logic [READING_WIDTH-1:0]          lat_r;

  logic [CHAN_FIELD_W-1:0]           out_chan_r;
  logic [READING_WIDTH-1:0]          out_avg_r;
  logic [READING_WIDTH-1:0]          out_lat_r;
  logic                              out_none_r;
  logic                              out_last_r;
  logic                              out_tvalid_r;

  logic                              in_acc;
  logic                              is_last;
  logic                              out_load;
  logic                              mem_rd_en;
  logic [AW-1:0]                     mem_rd_addr;
  logic [WORD_W-1:0]                 mem_rd_data;
  logic                              mem_wr_en;
  logic [AW-1:0]                     mem_wr_addr;
  logic [WORD_W-1:0]                 mem_wr_data;
  logic                              div_start;
  logic                              div_done;
  logic [READING_WIDTH-1:0]          div_q;

  logic [READING_WIDTH-1:0]          cur_reading;
  logic [SUM_WIDTH-1:0]              cur_sum;
  logic [READING_WIDTH-1:0]          cur_latest;

  assign in_acc      = in_tvalid && in_tready;
  assign is_last     = (ch_r == LAST_CH);
  assign cur_reading = smp_r[ch_r*READING_WIDTH +: READING_WIDTH];
  assign cur_sum     = mem_rd_data[SUM_WIDTH-1:0];
  assign cur_latest  = mem_rd_data[WORD_W-1 -: READING_WIDTH];

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_READ) begin
            state_nxt = ST_RD;
          end else if (count_r != COUNT_MAX) begin
            state_nxt = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        if (is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = is_last ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output logic of the sequencer: memory ports, divider start, result load.
  always_comb begin
    in_tready   = 1'b0;
    out_load    = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = ch_r;
    mem_wr_data = '0;
    div_start   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        mem_rd_en = in_tvalid;
      end
      ST_ADD: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {cur_reading,
                       cur_sum + {{(SUM_WIDTH-READING_WIDTH){cur_reading[READING_WIDTH-1]}},
                                  cur_reading}};
        mem_rd_en   = !is_last;
        mem_rd_addr = AW'(ch_r + 1'b1);
      end
      ST_RD: begin
        // Clear the sum, keep the latest reading, hand the sum to the divider.
        mem_wr_en   = 1'b1;
        mem_wr_data = {cur_latest, {SUM_WIDTH{1'b0}}};
        div_start   = 1'b1;
      end
      ST_DIV: begin
        div_start = 1'b0;
      end
      ST_OUT: begin
        out_load    = !out_tvalid_r || out_tready;
        mem_rd_en   = out_load && !is_last;
        mem_rd_addr = AW'(ch_r + 1'b1);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Control registers: state, channel pointer and sample count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && in_acc) begin
        ch_r <= '0;
        if (in_tuser == OP_READ) begin
          count_r <= '0;
        end else if (count_r != COUNT_MAX) begin
          count_r <= count_r + 1'b1;
        end
      end else if ((state_r == ST_ADD && !is_last) || (out_load && !is_last)) begin
        ch_r <= AW'(ch_r + 1'b1);
      end
    end
  end

  // Payload captured with the input word and per channel during a read.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      smp_r     <= in_tdata;
      divisor_r <= count_r;
      none_r    <= (count_r == '0);
    end
    if (state_r == ST_RD) begin
      lat_r <= cur_latest;
    end
  end

  // Output register; it parts the sequencer from the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan_r <= CHAN_FIELD_W'(ch_r);
      out_avg_r  <= none_r ? '0 : div_q;
      out_lat_r  <= lat_r;
      out_none_r <= none_r;
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-CHAN_FIELD_W-2*READING_WIDTH){1'b0}},
                       out_lat_r, out_avg_r, out_chan_r};
  assign out_tuser  = out_none_r;
  assign out_tlast  = out_last_r;

  mcaa_store #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  mcaa_div #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cur_sum),
    .divisor  (divisor_r),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

`default_nettype wire

/* sv/mcaa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the result channel.
module mcaa_checker
  import mcaa_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser,
  input wire logic                   out_tlast
);

  localparam logic [CHAN_FIELD_W-1:0] LAST_CHAN = CHAN_FIELD_W'(CHANNELS - 1);

  // A stalled word stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

  // The final word of a read describes the highest channel.
  `ASSERT_IMPLY(a_last_chan, clk, rst_n, out_tvalid && out_tlast, out_tdata[2:0] == LAST_CHAN)

  // With no samples the average is forced to zero.
  `ASSERT_IMPLY(a_none_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata[18:3] == 16'd0)

endmodule

bind multichannel_accumulate_average mcaa_checker #(
  .CHANNELS (CHANNELS)
) u_mcaa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
